### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define DIH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be seen out of reset
`define DIH_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### rtl/dih_pkg.sv
// shared types and constants of the dual indexed heap
package dih_pkg;

    localparam int HANDLE_BITS  = 10;
    localparam int HANDLES      = 1024;
    localparam int OUT_KEY_BITS = 32;
    localparam int COUNT_BITS   = 11;

    localparam logic [1:0] MODE_MIN    = 2'd0;
    localparam logic [1:0] MODE_MAX    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    typedef logic [3:0] op_t;

    localparam op_t OP_IDLE   = 4'd0;
    localparam op_t OP_CLEAR  = 4'd1;
    localparam op_t OP_ACCEPT = 4'd2;
    localparam op_t OP_LOC    = 4'd3;
    localparam op_t OP_LAST   = 4'd4;
    localparam op_t OP_UP_RD  = 4'd5;
    localparam op_t OP_UP_CMP = 4'd6;
    localparam op_t OP_DN_RDL = 4'd7;
    localparam op_t OP_DN_RDR = 4'd8;
    localparam op_t OP_DN_CMP = 4'd9;
    localparam op_t OP_FIN    = 4'd10;
    localparam op_t OP_DONE   = 4'd11;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] mode;
        logic       present;
        logic       full;
        logic       slot_ok;
        logic       slot_last;
        logic       at_root;
        logic       up_move;
        logic       down_req;
        logic       left_in;
        logic       dn_move;
    } sts_t;

endpackage

### rtl/dual_indexed_heap_unit.sv
// top level of the dual indexed heap
// A min heap and a max heap of (handle, key) entries with a per-handle position map.
// A transaction is taken when start is high and busy low; its result is shown for one
// cycle with done high and cannot be held off. After reset the position map is swept
// clear, one handle a cycle, and busy stays high until every handle is cleared. The time an
// insert or removal takes is set by the single read port of the heap memory: each level
// of a sift up needs one read and compare, each level of a sift down reads both children
// one after the other.
module dual_indexed_heap_unit import dih_pkg::*; #(
    parameter int HEAP_CAPACITY = 1024,
    parameter int KEY_BITS      = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [HANDLE_BITS-1:0]         handle,
    input  logic signed [OUT_KEY_BITS-1:0] key,
    output logic                           done,
    output logic [1:0]                     status,
    output logic                           min_valid,
    output logic signed [OUT_KEY_BITS-1:0] min_key,
    output logic [HANDLE_BITS-1:0]         min_handle,
    output logic                           max_valid,
    output logic signed [OUT_KEY_BITS-1:0] max_key,
    output logic [HANDLE_BITS-1:0]         max_handle,
    output logic [COUNT_BITS-1:0]          min_count,
    output logic [COUNT_BITS-1:0]          max_count
);

    cmd_t cmd;
    sts_t sts;

    dih_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dih_datapath #(
        .HEAP_CAPACITY (HEAP_CAPACITY),
        .KEY_BITS      (KEY_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .mode       (mode),
        .handle     (handle),
        .key        (key),
        .sts        (sts),
        .status     (status),
        .min_valid  (min_valid),
        .min_key    (min_key),
        .min_handle (min_handle),
        .max_valid  (max_valid),
        .max_key    (max_key),
        .max_handle (max_handle),
        .min_count  (min_count),
        .max_count  (max_count)
    );

endmodule

### rtl/dih_ram.sv
// generic single write port ram with registered read
module dih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/dih_ctrl.sv
// controller state machine of the dual indexed heap
module dih_ctrl import dih_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LOC    = 4'd2;
    localparam logic [3:0] S_LAST   = 4'd3;
    localparam logic [3:0] S_UP_RD  = 4'd4;
    localparam logic [3:0] S_UP_CMP = 4'd5;
    localparam logic [3:0] S_DN_RDL = 4'd6;
    localparam logic [3:0] S_DN_RDR = 4'd7;
    localparam logic [3:0] S_DN_CMP = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_LOC;
                end
            end
            S_LOC:
            begin
                cmd.op     = OP_LOC;
                state_next = S_DONE;
                if (sts.mode == MODE_MIN || sts.mode == MODE_MAX)
                begin
                    if (!sts.present && !sts.full)
                    begin
                        state_next = S_UP_RD;
                    end
                end
                else if (sts.mode == MODE_REMOVE)
                begin
                    if (sts.present && sts.slot_ok && !sts.slot_last)
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                cmd.op     = OP_LAST;
                state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                cmd.op = OP_UP_RD;
                if (!sts.at_root)
                begin
                    state_next = S_UP_CMP;
                end
                else
                begin
                    state_next = sts.down_req ? S_DN_RDL : S_FIN;
                end
            end
            S_UP_CMP:
            begin
                cmd.op = OP_UP_CMP;
                if (sts.up_move)
                begin
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = sts.down_req ? S_DN_RDL : S_FIN;
                end
            end
            S_DN_RDL:
            begin
                cmd.op     = OP_DN_RDL;
                state_next = sts.left_in ? S_DN_RDR : S_FIN;
            end
            S_DN_RDR:
            begin
                cmd.op     = OP_DN_RDR;
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd.op     = OP_DN_CMP;
                state_next = sts.dn_move ? S_DN_RDL : S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.op     = OP_DONE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

### rtl/dih_datapath.sv
// datapath of the dual indexed heap: heap slots, position map, counts, top entries
module dih_datapath import dih_pkg::*; #(
    parameter int HEAP_CAPACITY = 1024,
    parameter int KEY_BITS      = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cmd_t                           cmd,
    input  logic [1:0]                     mode,
    input  logic [HANDLE_BITS-1:0]         handle,
    input  logic signed [OUT_KEY_BITS-1:0] key,
    output sts_t                           sts,
    output logic [1:0]                     status,
    output logic                           min_valid,
    output logic signed [OUT_KEY_BITS-1:0] min_key,
    output logic [HANDLE_BITS-1:0]         min_handle,
    output logic                           max_valid,
    output logic signed [OUT_KEY_BITS-1:0] max_key,
    output logic [HANDLE_BITS-1:0]         max_handle,
    output logic [COUNT_BITS-1:0]          min_count,
    output logic [COUNT_BITS-1:0]          max_count
);

    localparam int KW = (KEY_BITS < OUT_KEY_BITS) ? KEY_BITS : OUT_KEY_BITS;
    localparam int SW = $clog2(HEAP_CAPACITY);
    localparam int CW = $clog2(HEAP_CAPACITY + 1);
    localparam int LW = SW + 2;
    localparam int HW = KW + HANDLE_BITS;
    localparam int AW = SW + 1;
    localparam int XW = SW + 2;

    function automatic logic ahead(input logic which, input logic signed [KW-1:0] a,
                                   input logic signed [KW-1:0] b);
        return which ? (a > b) : (a < b);
    endfunction

    logic [1:0]             mode_reg, mode_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic signed [KW-1:0]   key_reg, key_next;
    logic [1:0]             status_reg, status_next;
    logic                   w_reg, w_next;
    logic [SW-1:0]          i_reg, i_next;
    logic signed [KW-1:0]   mk_reg, mk_next;
    logic [HANDLE_BITS-1:0] mid_reg, mid_next;
    logic                   down_reg, down_next;
    logic signed [KW-1:0]   lk_reg, lk_next;
    logic [HANDLE_BITS-1:0] lid_reg, lid_next;
    logic [CW-1:0]          min_cnt_reg, min_cnt_next;
    logic [CW-1:0]          max_cnt_reg, max_cnt_next;
    logic signed [KW-1:0]   min_top_key_reg, min_top_key_next;
    logic [HANDLE_BITS-1:0] min_top_id_reg, min_top_id_next;
    logic signed [KW-1:0]   max_top_key_reg, max_top_key_next;
    logic [HANDLE_BITS-1:0] max_top_id_reg, max_top_id_next;
    logic [HANDLE_BITS-1:0] clr_reg, clr_next;

    logic                   loc_we;
    logic [HANDLE_BITS-1:0] loc_waddr, loc_raddr;
    logic [LW-1:0]          loc_wdata, loc_rdata;
    logic                   heap_we;
    logic [AW-1:0]          heap_waddr, heap_raddr;
    logic [HW-1:0]          heap_wdata, heap_rdata;

    dih_ram #(.WIDTH(LW), .DEPTH(HANDLES)) u_loc_ram (
        .clk   (clk),
        .we    (loc_we),
        .waddr (loc_waddr),
        .wdata (loc_wdata),
        .raddr (loc_raddr),
        .rdata (loc_rdata)
    );

    // both heaps share one ram, the top address bit picks the heap
    dih_ram #(.WIDTH(HW), .DEPTH(2 ** AW)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    logic                   l_present, l_which;
    logic [SW-1:0]          l_slot;
    logic                   ins_w;
    logic [CW-1:0]          n_ins, n_rem, n_w;
    logic                   full, slot_ok, slot_last;
    logic signed [KW-1:0]   rd_key;
    logic [HANDLE_BITS-1:0] rd_id;
    logic [SW-1:0]          parent;
    logic [XW-1:0]          l_ext, r_ext, n_ext;
    logic                   up_move, left_in, right_in, dn_move, take_left, take_right;
    logic signed [KW-1:0]   best_key;

    assign l_present = loc_rdata[LW-1];
    assign l_which   = loc_rdata[LW-2];
    assign l_slot    = loc_rdata[SW-1:0];
    assign ins_w     = mode_reg[0];
    assign n_ins     = ins_w ? max_cnt_reg : min_cnt_reg;
    assign n_rem     = l_which ? max_cnt_reg : min_cnt_reg;
    assign n_w       = w_reg ? max_cnt_reg : min_cnt_reg;
    assign full      = (n_ins == CW'(HEAP_CAPACITY));
    assign slot_ok   = (CW'(l_slot) < n_rem);
    assign slot_last = (CW'(l_slot) == n_rem - CW'(1));
    assign rd_key    = $signed(heap_rdata[HW-1:HANDLE_BITS]);
    assign rd_id     = heap_rdata[HANDLE_BITS-1:0];
    assign parent    = (i_reg - SW'(1)) >> 1;
    assign l_ext     = {1'b0, i_reg, 1'b1};
    assign r_ext     = l_ext + XW'(1);
    assign n_ext     = XW'(n_w);
    assign up_move   = ahead(w_reg, mk_reg, rd_key);
    assign left_in   = (l_ext < n_ext);
    assign right_in  = (r_ext < n_ext);
    // left child wins ties, right must beat the better of moving and left
    assign take_left  = ahead(w_reg, lk_reg, mk_reg);
    assign best_key   = take_left ? lk_reg : mk_reg;
    assign take_right = right_in && ahead(w_reg, rd_key, best_key);
    assign dn_move    = take_left || take_right;

    always_comb
    begin
        sts.clear_last = (clr_reg == HANDLE_BITS'(HANDLES - 1));
        sts.mode       = mode_reg;
        sts.present    = l_present;
        sts.full       = full;
        sts.slot_ok    = slot_ok;
        sts.slot_last  = slot_last;
        sts.at_root    = (i_reg == '0);
        sts.up_move    = up_move;
        sts.down_req   = down_reg;
        sts.left_in    = left_in;
        sts.dn_move    = dn_move;
    end

    always_comb
    begin
        mode_next        = mode_reg;
        handle_next      = handle_reg;
        key_next         = key_reg;
        status_next      = status_reg;
        w_next           = w_reg;
        i_next           = i_reg;
        mk_next          = mk_reg;
        mid_next         = mid_reg;
        down_next        = down_reg;
        lk_next          = lk_reg;
        lid_next         = lid_reg;
        min_cnt_next     = min_cnt_reg;
        max_cnt_next     = max_cnt_reg;
        min_top_key_next = min_top_key_reg;
        min_top_id_next  = min_top_id_reg;
        max_top_key_next = max_top_key_reg;
        max_top_id_next  = max_top_id_reg;
        clr_next         = clr_reg;
        loc_we           = 1'b0;
        loc_waddr        = handle_reg;
        loc_wdata        = '0;
        loc_raddr        = handle;
        heap_we          = 1'b0;
        heap_waddr       = {w_reg, i_reg};
        heap_wdata       = {mk_reg, mid_reg};
        heap_raddr       = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                loc_we    = 1'b1;
                loc_waddr = clr_reg;
                clr_next  = clr_reg + HANDLE_BITS'(1);
            end
            OP_ACCEPT:
            begin
                mode_next   = mode;
                handle_next = handle;
                key_next    = $signed(key[KW-1:0]);
            end
            OP_LOC:
            begin
                heap_raddr  = {l_which, SW'(n_rem - CW'(1))};
                status_next = ST_DONE;
                down_next   = 1'b0;
                case (mode_reg)
                    MODE_MIN, MODE_MAX:
                    begin
                        if (l_present)
                        begin
                            status_next = ST_PRESENT;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            if (ins_w)
                            begin
                                max_cnt_next = n_ins + CW'(1);
                            end
                            else
                            begin
                                min_cnt_next = n_ins + CW'(1);
                            end
                            w_next   = ins_w;
                            i_next   = SW'(n_ins);
                            mk_next  = key_reg;
                            mid_next = handle_reg;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!l_present)
                        begin
                            status_next = ST_ABSENT;
                        end
                        else
                        begin
                            loc_we    = 1'b1;
                            w_next    = l_which;
                            i_next    = l_slot;
                            down_next = 1'b1;
                            if (slot_ok)
                            begin
                                if (l_which)
                                begin
                                    max_cnt_next = n_rem - CW'(1);
                                end
                                else
                                begin
                                    min_cnt_next = n_rem - CW'(1);
                                end
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_DONE;
                    end
                endcase
            end
            OP_LAST:
            begin
                mk_next  = rd_key;
                mid_next = rd_id;
            end
            OP_UP_RD:
            begin
                heap_raddr = {w_reg, parent};
            end
            OP_UP_CMP:
            begin
                if (up_move)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    loc_we     = 1'b1;
                    loc_waddr  = rd_id;
                    loc_wdata  = {1'b1, w_reg, i_reg};
                    i_next     = parent;
                end
            end
            OP_DN_RDL:
            begin
                heap_raddr = {w_reg, l_ext[SW-1:0]};
            end
            OP_DN_RDR:
            begin
                lk_next    = rd_key;
                lid_next   = rd_id;
                heap_raddr = {w_reg, r_ext[SW-1:0]};
            end
            OP_DN_CMP:
            begin
                if (dn_move)
                begin
                    heap_we   = 1'b1;
                    loc_we    = 1'b1;
                    loc_wdata = {1'b1, w_reg, i_reg};
                    if (take_right)
                    begin
                        heap_wdata = heap_rdata;
                        loc_waddr  = rd_id;
                        i_next     = r_ext[SW-1:0];
                    end
                    else
                    begin
                        heap_wdata = {lk_reg, lid_reg};
                        loc_waddr  = lid_reg;
                        i_next     = l_ext[SW-1:0];
                    end
                end
            end
            OP_FIN:
            begin
                heap_we   = 1'b1;
                loc_we    = 1'b1;
                loc_waddr = mid_reg;
                loc_wdata = {1'b1, w_reg, i_reg};
            end
            default:
            begin
            end
        endcase
        // keep a copy of each heap root
        if (heap_we && heap_waddr[SW-1:0] == '0)
        begin
            if (heap_waddr[SW])
            begin
                max_top_key_next = $signed(heap_wdata[HW-1:HANDLE_BITS]);
                max_top_id_next  = heap_wdata[HANDLE_BITS-1:0];
            end
            else
            begin
                min_top_key_next = $signed(heap_wdata[HW-1:HANDLE_BITS]);
                min_top_id_next  = heap_wdata[HANDLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cnt_reg <= '0;
            max_cnt_reg <= '0;
            clr_reg     <= '0;
            status_reg  <= ST_DONE;
            down_reg    <= 1'b0;
        end
        else
        begin
            min_cnt_reg <= min_cnt_next;
            max_cnt_reg <= max_cnt_next;
            clr_reg     <= clr_next;
            status_reg  <= status_next;
            down_reg    <= down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        handle_reg      <= handle_next;
        key_reg         <= key_next;
        w_reg           <= w_next;
        i_reg           <= i_next;
        mk_reg          <= mk_next;
        mid_reg         <= mid_next;
        lk_reg          <= lk_next;
        lid_reg         <= lid_next;
        min_top_key_reg <= min_top_key_next;
        min_top_id_reg  <= min_top_id_next;
        max_top_key_reg <= max_top_key_next;
        max_top_id_reg  <= max_top_id_next;
    end

    assign status     = status_reg;
    assign min_valid  = (min_cnt_reg != '0);
    assign max_valid  = (max_cnt_reg != '0);
    assign min_key    = min_valid ? OUT_KEY_BITS'(min_top_key_reg) : '0;
    assign max_key    = max_valid ? OUT_KEY_BITS'(max_top_key_reg) : '0;
    assign min_handle = min_valid ? min_top_id_reg : '0;
    assign max_handle = max_valid ? max_top_id_reg : '0;
    assign min_count  = COUNT_BITS'(min_cnt_reg);
    assign max_count  = COUNT_BITS'(max_cnt_reg);

endmodule

### rtl/dih_checker.sv
// port level checks of the dual indexed heap and their bind
`include "assert_macros.svh"

module dih_checker import dih_pkg::*; (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [1:0]                     mode,
    input logic [HANDLE_BITS-1:0]         handle,
    input logic signed [OUT_KEY_BITS-1:0] key,
    input logic                           done,
    input logic [1:0]                     status,
    input logic                           min_valid,
    input logic signed [OUT_KEY_BITS-1:0] min_key,
    input logic [HANDLE_BITS-1:0]         min_handle,
    input logic                           max_valid,
    input logic signed [OUT_KEY_BITS-1:0] max_key,
    input logic [HANDLE_BITS-1:0]         max_handle,
    input logic [COUNT_BITS-1:0]          min_count,
    input logic [COUNT_BITS-1:0]          max_count
);

    // a result only comes while a transaction is in flight
    `DIH_ASSERT(a_done_busy, clk, rst_n, done |-> busy)
    // an accepted transaction holds the block busy
    `DIH_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    // a result is a single cycle strobe
    `DIH_ASSERT(a_done_pulse, clk, rst_n, done |=> !done)
    // an empty min heap shows no top entry
    `DIH_ASSERT(a_min_empty, clk, rst_n,
        (done && !min_valid) |-> (min_count == '0 && min_key == '0 && min_handle == '0))
    // an empty max heap shows no count
    `DIH_NEVER(a_max_empty, clk, rst_n, done && !max_valid && max_count != '0)

endmodule

bind dual_indexed_heap_unit dih_checker u_dih_checker (.*);
